[rtl/fhm_pkg.sv]
// Shared types and constants for the FIFO handoff mutex.
package fhm_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;
  localparam int OUT_ID_W        = 8;
  localparam int STATUS_W        = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_RELEASED = 3'd4,
    ST_HANDOFF  = 3'd5
  } fhm_status_t;

  typedef enum logic {
    MODE_LOCK   = 1'b0,
    MODE_UNLOCK = 1'b1
  } fhm_mode_t;

  // Queue command broadcast to every cell of the wait chain.
  typedef struct packed {
    logic push;
    logic pop;
  } fhm_qctl_t;

endpackage

[rtl/fhm_ifs.sv]
// Request and result channel interfaces of the FIFO handoff mutex.
interface fhm_req_if #(
  parameter int ID_W = fhm_pkg::ID_WIDTH_DEF
);
  logic            valid;
  logic            ready;
  logic            mode;
  logic [ID_W-1:0] requester_id;

  modport source (output valid, output mode, output requester_id, input ready);
  modport sink   (input valid, input mode, input requester_id, output ready);
endinterface

interface fhm_rsp_if;
  import fhm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OUT_ID_W-1:0] woken_id;
  logic                is_locked;
  logic [OUT_ID_W-1:0] holder_id;

  modport source (output valid, output status, output woken_id, output is_locked,
                  output holder_id, input ready);
  modport sink   (input valid, input status, input woken_id, input is_locked,
                  input holder_id, output ready);
endinterface

[rtl/fhm_cell.sv]
// One slot of the wait chain: holds a waiter id and shifts toward the head.
module fhm_cell #(
  parameter int ID_W = fhm_pkg::ID_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fhm_pkg::fhm_qctl_t ctl,
  input  logic [ID_W-1:0]   push_id,
  input  logic              prev_valid,
  input  logic              next_valid,
  input  logic [ID_W-1:0]   next_id,
  output logic              valid_o,
  output logic [ID_W-1:0]   id_o
);
  import fhm_pkg::*;

  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (ctl.pop) begin
      // advance: take the neighbor behind us
      valid_nxt = next_valid;
      id_nxt    = next_id;
    end else if (ctl.push && prev_valid && !valid_r) begin
      // first free slot takes the new waiter
      valid_nxt = 1'b1;
      id_nxt    = push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign valid_o = valid_r;
  assign id_o    = id_r;
endmodule

[rtl/fhm_wait_queue.sv]
// Wait queue built as a shifting chain of cells, oldest waiter in cell zero.
module fhm_wait_queue #(
  parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_W        = fhm_pkg::ID_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fhm_pkg::fhm_qctl_t ctl,
  input  logic [ID_W-1:0]   push_id,
  output logic              full,
  output logic              head_valid,
  output logic [ID_W-1:0]   head_id
);
  import fhm_pkg::*;

  logic [QUEUE_DEPTH-1:0] valid;
  logic [ID_W-1:0]        ids [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            prev_v;
    logic            next_v;
    logic [ID_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_d = ids[i];
    end else begin : g_inner
      assign next_v = valid[i+1];
      assign next_d = ids[i+1];
    end

    fhm_cell #(.ID_W(ID_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_id    (push_id),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_id    (next_d),
      .valid_o    (valid[i]),
      .id_o       (ids[i])
    );
  end

  assign full       = valid[QUEUE_DEPTH-1];
  assign head_valid = valid[0];
  assign head_id    = ids[0];
endmodule

[rtl/fhm_ctrl.sv]
// Ownership register and per-request decision logic of the mutex.
module fhm_ctrl #(
  parameter int ID_W = fhm_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          mode,
  input  logic [ID_W-1:0]               req_id,
  input  logic                          q_full,
  input  logic                          q_head_valid,
  input  logic [ID_W-1:0]               q_head_id,
  output fhm_pkg::fhm_qctl_t            qctl,
  output fhm_pkg::fhm_status_t          status,
  output logic [ID_W-1:0]               woken,
  output logic                          held_after,
  output logic [ID_W-1:0]               owner_after
);
  import fhm_pkg::*;

  logic            held_r, held_nxt;
  logic [ID_W-1:0] owner_r, owner_nxt;

  always_comb begin
    held_nxt  = held_r;
    owner_nxt = owner_r;
    qctl      = '0;
    woken     = '0;
    if (mode == MODE_LOCK) begin
      if (!held_r) begin
        held_nxt  = 1'b1;
        owner_nxt = req_id;
        status    = ST_GRANTED;
      end else if (q_full) begin
        status    = ST_DROPPED;
      end else begin
        qctl.push = accept;
        status    = ST_QUEUED;
      end
    end else begin
      if (!held_r || owner_r != req_id) begin
        status    = ST_REJECTED;
      end else if (q_head_valid) begin
        qctl.pop  = accept;
        woken     = q_head_id;
        owner_nxt = q_head_id;
        status    = ST_HANDOFF;
      end else begin
        held_nxt  = 1'b0;
        owner_nxt = '0;
        status    = ST_RELEASED;
      end
    end
  end

  assign held_after  = held_nxt;
  assign owner_after = held_nxt ? owner_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      owner_r <= '0;
    end else if (accept) begin
      held_r  <= held_nxt;
      owner_r <= owner_nxt;
    end
  end
endmodule

[rtl/fifo_handoff_mutex.sv]
// Top level of the FIFO handoff mutex: request decoding, wait chain and result register.
// A hardware mutex with a first-in first-out queue of waiters. Each request on
// in_req is a lock (mode 0) or an unlock (mode 1) tagged with a requester id and
// yields exactly one result on out_rsp. A lock on a free mutex is granted at once;
// a lock on a held mutex joins the wait queue, or is dropped when QUEUE_DEPTH
// waiters already wait. Only the owner may unlock: its unlock hands ownership to
// the oldest waiter, or frees the mutex when no one waits. A repeated lock by the
// owner is queued like any other. The block takes one request per clock cycle;
// the result is written into the output register in the cycle after the request is
// accepted, and a new request is taken whenever that register is empty or is
// being drained in the same cycle. The wait queue is a row of QUEUE_DEPTH cells
// that shifts one place toward the head on every handoff. No clearing pass is
// needed after reset.
module fifo_handoff_mutex #(
  parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = fhm_pkg::ID_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  fhm_req_if.sink     in_req,
  fhm_rsp_if.source   out_rsp
);
  import fhm_pkg::*;

  logic            accept;
  fhm_qctl_t       qctl;
  logic            q_full;
  logic            q_head_valid;
  logic [ID_WIDTH-1:0] q_head_id;

  fhm_status_t     status;
  logic [ID_WIDTH-1:0] woken;
  logic            held_after;
  logic [ID_WIDTH-1:0] owner_after;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [OUT_ID_W-1:0] woken_r;
  logic                locked_r;
  logic [OUT_ID_W-1:0] holder_r;

  // Fit ids to the fixed result width: zero-extend, then keep the low bits.
  logic [ID_WIDTH+OUT_ID_W-1:0] woken_ext;
  logic [ID_WIDTH+OUT_ID_W-1:0] holder_ext;

  // Take a request whenever the result slot is free or drains this cycle.
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  fhm_ctrl #(.ID_W(ID_WIDTH)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .mode         (in_req.mode),
    .req_id       (in_req.requester_id),
    .q_full       (q_full),
    .q_head_valid (q_head_valid),
    .q_head_id    (q_head_id),
    .qctl         (qctl),
    .status       (status),
    .woken        (woken),
    .held_after   (held_after),
    .owner_after  (owner_after)
  );

  fhm_wait_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_W        (ID_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (qctl),
    .push_id    (in_req.requester_id),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_id    (q_head_id)
  );

  assign woken_ext  = {{OUT_ID_W{1'b0}}, woken};
  assign holder_ext = {{OUT_ID_W{1'b0}}, owner_after};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      // drop the result once taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until a new request replaces it.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      woken_r  <= woken_ext[OUT_ID_W-1:0];
      locked_r <= held_after;
      holder_r <= holder_ext[OUT_ID_W-1:0];
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.woken_id  = woken_r;
  assign out_rsp.is_locked = locked_r;
  assign out_rsp.holder_id = holder_r;
endmodule

[tb/tb.sv]
// Self-checking testbench for the FIFO handoff mutex: random and directed requests.
`timescale 1ns / 1ps

module tb;
  import fhm_pkg::*;

  localparam int WAIT_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int REQ_ID_W    = ID_WIDTH_DEF;
  localparam int RANDOM_REQS = 1224;
  localparam int BLOCK_LEN   = 40;
  localparam int LONG_HOLD   = 300;

  // One result as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_ID_W-1:0] woken_id;
    logic                is_locked;
    logic [OUT_ID_W-1:0] holder_id;
  } mutex_result_t;

  // Mutex predictor plus the store of results still owed by the block.
  class mutex_scoreboard;
    bit                  held;
    logic [REQ_ID_W-1:0] owner;
    logic [REQ_ID_W-1:0] waiters[$];
    mutex_result_t       owed_results[$];
    int                  errors;
    int                  checked;
    int                  status_seen[6];

    // Advance the mutex state by one accepted request and store its result.
    function void note_request(fhm_mode_t mode, logic [REQ_ID_W-1:0] id);
      mutex_result_t res;
      res = '0;
      if (mode == MODE_LOCK) begin
        if (!held) begin
          held       = 1'b1;
          owner      = id;
          res.status = ST_GRANTED;
        end else if (waiters.size() >= WAIT_DEPTH) begin
          res.status = ST_DROPPED;
        end else begin
          waiters.push_back(id);
          res.status = ST_QUEUED;
        end
      end else begin
        if (!held || owner != id) begin
          res.status = ST_REJECTED;
        end else if (waiters.size() > 0) begin
          owner        = waiters.pop_front();
          res.woken_id = owner;
          res.status   = ST_HANDOFF;
        end else begin
          held       = 1'b0;
          owner      = '0;
          res.status = ST_RELEASED;
        end
      end
      res.is_locked = held;
      res.holder_id = held ? owner : '0;
      owed_results.push_back(res);
    endfunction

    // Compare one delivered result with the oldest owed one.
    function void check_result(mutex_result_t got);
      mutex_result_t exp_res;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d woken=%0d locked=%0d holder=%0d",
                 $time, got.status, got.woken_id, got.is_locked, got.holder_id);
        errors++;
        return;
      end
      exp_res = owed_results.pop_front();
      checked++;
      if (exp_res.status < 6) status_seen[exp_res.status]++;
      if (got !== exp_res) begin
        $display("%0t: mismatch expected status=%0d woken=%0d locked=%0d holder=%0d",
                 $time, exp_res.status, exp_res.woken_id, exp_res.is_locked,
                 exp_res.holder_id);
        $display("%0t:          actual   status=%0d woken=%0d locked=%0d holder=%0d",
                 $time, got.status, got.woken_id, got.is_locked, got.holder_id);
        errors++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fhm_req_if #(.ID_W(REQ_ID_W)) req_if ();
  fhm_rsp_if                    rsp_if ();

  fifo_handoff_mutex i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  mutex_scoreboard sb = new;

  // Stimulus-side knobs and counters; the long-hold flags are shared with the receiver process.
  bit sender_steady;
  bit long_hold_req;
  int long_holds_done;
  int requests_sent;
  int drain_pauses;
  logic [REQ_ID_W-1:0] id_pool[4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drive every input to a known value, hold reset, then release.
  initial begin
    req_if.valid        <= 1'b0;
    req_if.mode         <= MODE_LOCK;
    req_if.requester_id <= '0;
    rsp_if.ready        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Check every result taken from the output channel. The edge samples values
  // from before the nonblocking updates, so the order of processes does not matter.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      sb.check_result('{status:    rsp_if.status,
                        woken_id:  rsp_if.woken_id,
                        is_locked: rsp_if.is_locked,
                        holder_id: rsp_if.holder_id});
    end
  end

  // Result receiver: insert random stalls between results, flip between steady and
  // stalling stretches now and then, and hold off for a long stretch on request.
  initial begin
    int  stall;
    bit  recv_steady;
    recv_steady = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds_done++;
        stall = LONG_HOLD;
      end else begin
        stall = recv_steady ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // Offer one request after an optional idle gap and note it once accepted.
  task automatic send_request(fhm_mode_t mode, logic [REQ_ID_W-1:0] id);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= mode;
    req_if.requester_id <= id;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(mode, id);
    requests_sent++;
  endtask

  // Drop valid and hold until the block has delivered every owed result.
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    drain_pauses++;
  endtask

  // Pick a request that mostly follows a legal lock/unlock pattern: locks from a small
  // id pool or at times by the owner, unlocks mostly by the current owner, plus some noise.
  task automatic send_random_request(int lock_pct);
    fhm_mode_t           mode;
    logic [REQ_ID_W-1:0] id;
    if ($urandom_range(0, 9) == 0) begin
      mode = $urandom_range(0, 1) ? MODE_UNLOCK : MODE_LOCK;
      id   = REQ_ID_W'($urandom_range(0, 255));
    end else if ($urandom_range(0, 99) < lock_pct) begin
      mode = MODE_LOCK;
      id   = (sb.held && $urandom_range(0, 7) == 0) ? sb.owner
                                                    : id_pool[2'($urandom_range(0, 3))];
    end else begin
      mode = MODE_UNLOCK;
      id   = ($urandom_range(0, 9) == 0) ? id_pool[2'($urandom_range(0, 3))] : sb.owner;
    end
    send_request(mode, id);
  endtask

  initial begin
    int lock_pct;
    int blk;
    int n;
    sender_steady   = 1'b0;
    long_hold_req   = 1'b0;
    long_holds_done = 0;
    requests_sent   = 0;
    drain_pauses    = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Directed: unlock of a free mutex, grant, queue, non-owner unlock,
    // owner relocking, handoffs, release, then fill the queue and overflow it.
    send_request(MODE_UNLOCK, 8'h00);
    send_request(MODE_LOCK,   8'h00);
    send_request(MODE_LOCK,   8'hFF);
    send_request(MODE_UNLOCK, 8'hFF);
    send_request(MODE_LOCK,   8'h00);
    send_request(MODE_UNLOCK, 8'h00);
    send_request(MODE_UNLOCK, 8'hFF);
    send_request(MODE_UNLOCK, 8'h00);
    send_request(MODE_LOCK,   8'hAA);
    for (int i = 0; i < WAIT_DEPTH; i++) send_request(MODE_LOCK, 8'(i * 17));
    send_request(MODE_LOCK,   8'h5A);
    wait_results_drained();

    // Random: blocks of requests with a lock-heavy, balanced or unlock-heavy
    // mix, so the queue both fills to overflow and drains to empty.
    blk = 0;
    n   = 0;
    while (n < RANDOM_REQS) begin
      case ($urandom_range(0, 2))
        0:       lock_pct = 15;
        1:       lock_pct = 50;
        default: lock_pct = 85;
      endcase
      for (int k = 0; k < 4; k++) id_pool[k] = REQ_ID_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) id_pool[0] = 8'hFF;
      if ($urandom_range(0, 3) == 0) id_pool[1] = 8'h00;
      sender_steady = ($urandom_range(0, 3) == 0);
      // Once: stall the receiver for a long stretch while requests keep coming.
      if (blk == 8) begin
        sender_steady = 1'b1;
        long_hold_req = 1'b1;
      end
      for (int k = 0; k < BLOCK_LEN && n < RANDOM_REQS; k++) begin
        send_random_request(lock_pct);
        n++;
      end
      if (blk == 4 || blk == 15 || blk == 25) wait_results_drained();
      blk++;
    end

    wait_results_drained();
    repeat (20) @(posedge clk);

    $display("tb: %0d requests sent, %0d results checked, %0d drain pauses, %0d long stalls",
             requests_sent, sb.checked, drain_pauses, long_holds_done);
    $display("tb: granted %0d queued %0d dropped %0d rejected %0d released %0d handed off %0d",
             sb.status_seen[ST_GRANTED], sb.status_seen[ST_QUEUED],
             sb.status_seen[ST_DROPPED], sb.status_seen[ST_REJECTED],
             sb.status_seen[ST_RELEASED], sb.status_seen[ST_HANDOFF]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[fifo_handoff_mutex.f]
rtl/fhm_pkg.sv
rtl/fhm_ifs.sv
rtl/fhm_cell.sv
rtl/fhm_wait_queue.sv
rtl/fhm_ctrl.sv
rtl/fifo_handoff_mutex.sv
tb/tb.sv
